// File: src/assert_macros.svh
// Assertion macros shared by the reorder buffer modules.
// No dependencies; included by the files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/srb_pkg.sv
// Types and constants of the sequence reorder buffer.
// No dependencies; used by srb_front, srb_back and sequence_reorder_buffer.
package srb_pkg;

  localparam int SEQ_BITS     = 32;
  localparam int PAYLOAD_BITS = 16;
  // Reorder window in slots; must be a power of two (2 to 64).
  localparam int WINDOW       = 16;
  localparam int SLOT_BITS    = $clog2(WINDOW);
  localparam int HANDLE_BITS  = 16;
  // Handle bits actually kept: the payload field is only 16 bits wide.
  localparam int STORE_BITS   = (HANDLE_BITS < PAYLOAD_BITS) ? HANDLE_BITS : PAYLOAD_BITS;

  // Command queue between front and back.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_DELIVER = 2'd0;
  localparam logic [1:0] KIND_DUP     = 2'd1;
  localparam logic [1:0] KIND_HELD    = 2'd2;
  localparam logic [1:0] KIND_BEYOND  = 2'd3;

  typedef struct packed {
    logic [SEQ_BITS-1:0]     seq_number;
    logic [PAYLOAD_BITS-1:0] payload_handle;
  } item_t;

  typedef struct packed {
    logic [PAYLOAD_BITS-1:0] out_handle;
    logic [SEQ_BITS-1:0]     out_seq;
    logic [1:0]              kind;
    logic                    last;
  } result_t;

  // One queued command: the item plus the mode it was accepted under.
  typedef struct packed {
    logic [SEQ_BITS-1:0]   seq;
    logic [STORE_BITS-1:0] handle;
    logic                  reorder;
  } cmd_t;

endpackage

// File: src/srb_front.sv
// Front of the reorder buffer: mode register, item intake and command queue.
// Depends on srb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srb_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  srb_pkg::item_t item,
  input  logic          reorder_write,
  input  logic          reorder_data,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output srb_pkg::cmd_t cmd
);

  logic                          reorder_enable;
  srb_pkg::cmd_t                 queue [srb_pkg::QUEUE_DEPTH];
  logic [srb_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [srb_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [srb_pkg::QPTR_BITS:0]   count;
  logic                          push;
  logic                          pop;
  srb_pkg::cmd_t                 new_cmd;

  localparam logic [srb_pkg::QPTR_BITS:0] FULL_COUNT =
    (srb_pkg::QPTR_BITS + 1)'(srb_pkg::QUEUE_DEPTH);
  localparam logic [srb_pkg::QPTR_BITS-1:0] LAST_PTR =
    srb_pkg::QPTR_BITS'(srb_pkg::QUEUE_DEPTH - 1);

  assign item_ready = (count != FULL_COUNT);
  assign cmd_valid  = (count != '0);
  assign cmd        = queue[rd_ptr];
  assign push       = item_valid && item_ready;
  assign pop        = cmd_valid && cmd_ready;

  // Tag the item with the current mode and trim the handle to its stored width.
  always_comb begin
    new_cmd.seq     = item.seq_number;
    new_cmd.handle  = srb_pkg::STORE_BITS'(item.payload_handle);
    new_cmd.reorder = reorder_enable;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reorder_enable <= 1'b1;
    end else if (reorder_write) begin
      reorder_enable <= reorder_data;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ASSERT_NEXT(a_push_lands, clk, rst, push, cmd_valid, "accepted item missing from queue")
  `ASSERT_IMPLY(a_pop_only_valid, clk, rst, cmd_ready && !cmd_valid, !pop, "pop from empty queue")
  `ASSERT_NEXT(a_full_blocks, clk, rst, (count == FULL_COUNT) && !pop, !item_ready,
               "full queue accepts an item")

endmodule

// File: src/srb_back.sv
// Back of the reorder buffer: classify, hold window, release runs, result register.
// Depends on srb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module srb_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  output logic             cmd_ready,
  input  srb_pkg::cmd_t    cmd,
  output logic             result_valid,
  input  logic             result_ready,
  output srb_pkg::result_t result
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [srb_pkg::SEQ_BITS-1:0]    expected;
  logic [srb_pkg::SEQ_BITS-1:0]    expected_next;
  logic [srb_pkg::WINDOW-1:0]      slot_valid;
  logic [srb_pkg::WINDOW-1:0]      slot_valid_next;
  logic [srb_pkg::STORE_BITS-1:0]  slot_handle [srb_pkg::WINDOW];
  logic [srb_pkg::STORE_BITS-1:0]  handle_q;
  logic [srb_pkg::SLOT_BITS:0]     run_count;
  logic [srb_pkg::SLOT_BITS:0]     run_count_next;
  logic                            emit;
  srb_pkg::result_t                result_next;
  logic                            mem_we;
  logic [srb_pkg::SLOT_BITS-1:0]   mem_waddr;
  logic                            out_free;
  logic [srb_pkg::SEQ_BITS-1:0]    exp_inc;
  logic [srb_pkg::SEQ_BITS-1:0]    ahead;
  logic [srb_pkg::SLOT_BITS-1:0]   slot_cur;
  logic [srb_pkg::SLOT_BITS-1:0]   slot_inc;
  logic [srb_pkg::SLOT_BITS:0]     count_inc;

  localparam logic [srb_pkg::SLOT_BITS:0] RUN_MAX =
    (srb_pkg::SLOT_BITS + 1)'(srb_pkg::WINDOW);

  assign out_free  = !result_valid || result_ready;
  assign exp_inc   = expected + 1'b1;
  assign ahead     = cmd.seq - expected;
  assign slot_cur  = expected[srb_pkg::SLOT_BITS-1:0];
  assign slot_inc  = exp_inc[srb_pkg::SLOT_BITS-1:0];
  assign count_inc = run_count + 1'b1;
  assign cmd_ready = (state == S_IDLE) && out_free;

  always_comb begin
    state_next      = state;
    expected_next   = expected;
    slot_valid_next = slot_valid;
    run_count_next  = run_count;
    emit            = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = cmd.seq[srb_pkg::SLOT_BITS-1:0];
    result_next     = result;

    unique case (state)
      S_IDLE: begin
        if (cmd_valid && out_free) begin
          emit                = 1'b1;
          result_next.out_seq = cmd.seq;
          result_next.last    = 1'b1;
          result_next.out_handle = '0;
          if (!cmd.reorder) begin
            // Pass through and keep the window ahead of the new expected number.
            result_next.kind       = srb_pkg::KIND_DELIVER;
            result_next.out_handle = srb_pkg::PAYLOAD_BITS'(cmd.handle);
            expected_next          = exp_inc;
            slot_valid_next[slot_inc] = 1'b0;
          end else if (cmd.seq < expected) begin
            result_next.kind = srb_pkg::KIND_DUP;
          end else if (cmd.seq != expected) begin
            if (ahead < srb_pkg::SEQ_BITS'(srb_pkg::WINDOW)) begin
              result_next.kind = srb_pkg::KIND_HELD;
              mem_we           = 1'b1;
              slot_valid_next[mem_waddr] = 1'b1;
            end else begin
              result_next.kind = srb_pkg::KIND_BEYOND;
            end
          end else begin
            // In order: deliver, then release the held run if one follows.
            result_next.kind       = srb_pkg::KIND_DELIVER;
            result_next.out_handle = srb_pkg::PAYLOAD_BITS'(cmd.handle);
            result_next.last       = !slot_valid[slot_inc];
            expected_next          = exp_inc;
            run_count_next         = (srb_pkg::SLOT_BITS + 1)'(1);
            if (slot_valid[slot_inc]) begin
              state_next = S_RUN;
            end
          end
        end
      end
      S_RUN: begin
        if (out_free) begin
          emit                      = 1'b1;
          result_next.kind          = srb_pkg::KIND_DELIVER;
          result_next.out_handle    = srb_pkg::PAYLOAD_BITS'(handle_q);
          result_next.out_seq       = expected;
          result_next.last          = !slot_valid[slot_inc] || (count_inc == RUN_MAX);
          slot_valid_next[slot_cur] = 1'b0;
          expected_next             = exp_inc;
          run_count_next            = count_inc;
          if (result_next.last) begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      expected   <= '0;
      slot_valid <= '0;
      run_count  <= '0;
    end else begin
      state      <= state_next;
      expected   <= expected_next;
      slot_valid <= slot_valid_next;
      run_count  <= run_count_next;
    end
  end

  // Handle store; the read tracks the slot of the next expected number.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_handle[mem_waddr] <= cmd.handle;
    end
    handle_q <= slot_handle[expected_next[srb_pkg::SLOT_BITS-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (emit) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= result_next;
    end
  end

  `ASSERT_IMPLY(a_run_no_pop, clk, rst, state == S_RUN, !cmd_ready, "command taken during release")
  `ASSERT_IMPLY(a_run_slot_held, clk, rst, state == S_RUN, slot_valid[slot_cur],
                "release run reached an empty slot")
  `ASSERT_IMPLY(a_idle_slot_free, clk, rst, state == S_IDLE, !slot_valid[slot_cur],
                "expected slot marked held while idle")
  `ASSERT_IMPLY(a_report_is_last, clk, rst,
                result_valid && (result.kind != srb_pkg::KIND_DELIVER), result.last,
                "report result not marked last")

endmodule

// File: src/sequence_reorder_buffer.sv
// Sequence reorder buffer top level, built from srb_front and srb_back over srb_pkg.
// An accepted item is registered in the command queue, and its result in the result
// register. The back makes one result per cycle while results are not stalled and
// takes no new command during a run release; a two-entry command queue lets intake
// continue while results stall. Reset clears the expected number, all valid marks
// and the queue, and sets reorder_enable; the handle store is not cleared.

module sequence_reorder_buffer (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  srb_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output srb_pkg::result_t result,
  input  logic             reorder_write,
  input  logic             reorder_data
);

  logic          cmd_valid;
  logic          cmd_ready;
  srb_pkg::cmd_t cmd;

  srb_front u_front (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .reorder_write(reorder_write),
    .reorder_data (reorder_data),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .cmd          (cmd)
  );

  srb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_valid),
    .cmd_ready   (cmd_ready),
    .cmd         (cmd),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

endmodule
